// ===== src/area_fit_even_scaler_macros.svh =====
// ----------------------------------------------------------------------------
// area_fit_even_scaler assertion macros
// Shared property forms for the port checker of the area fit scaler.
// ----------------------------------------------------------------------------
`ifndef AREA_FIT_EVEN_SCALER_MACROS_SVH
`define AREA_FIT_EVEN_SCALER_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define AFES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("area fit scaler check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define AFES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("area fit scaler check failed");

`endif

// ===== src/afes_pkg.sv =====
// ----------------------------------------------------------------------------
// afes_pkg
// Types and constants shared by the area fit scaler modules.
// ----------------------------------------------------------------------------
package afes_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int PORT_W = 16;
	localparam logic [31:0] EVEN_MASK = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		OUTCOME_ZERO   = 2'd0,
		OUTCOME_PASS   = 2'd1,
		OUTCOME_SCALED = 2'd2
	} outcome_t;

endpackage

// ===== src/afes_div.sv =====
// ----------------------------------------------------------------------------
// afes_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module afes_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] num,
	input  logic [W-1:0]   den,
	output logic [W-1:0]   quo
);

	// The caller guarantees num / den fits in W bits, so the upper half of
	// num is already below den and serves as the starting remainder.
	logic [W-1:0] rem_s [0:W];
	logic [W-1:0] low_s [0:W];
	logic [W-1:0] quo_s [0:W];
	logic [W-1:0] den_s [0:W];

	assign rem_s[0] = num[2*W-1:W];
	assign low_s[0] = num[W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		logic       ge;

		assign trial = {rem_s[i], low_s[i][W-1]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign ge    = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
				low_s[i+1] <= {low_s[i][W-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][W-2:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign quo = quo_s[W];

endmodule

// ===== src/afes_sqrt.sv =====
// ----------------------------------------------------------------------------
// afes_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module afes_sqrt #(
	parameter int R = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*R-1:0] val,
	output logic [R-1:0]   root
);

	logic [R+1:0]   rem_s  [0:R];
	logic [R-1:0]   root_s [0:R];
	logic [2*R-1:0] val_s  [0:R];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign val_s[0]  = val;

	for (genvar i = 0; i < R; i++) begin : g_stage
		logic [R+3:0] t;
		logic [R+3:0] trial;
		logic [R+3:0] diff;
		logic         ge;

		// Bring down the next two bits and try appending a one to the root.
		assign t     = {rem_s[i], val_s[i][2*R-1:2*R-2]};
		assign trial = (R+4)'({root_s[i], 2'b01});
		assign diff  = t - trial;
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[R+1:0] : t[R+1:0];
				root_s[i+1] <= {root_s[i][R-2:0], ge};
				val_s[i+1]  <= {val_s[i][2*R-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[R];

endmodule

// ===== src/area_fit_even_scaler.sv =====
// ----------------------------------------------------------------------------
// area_fit_even_scaler
// Fits a source size into a destination area, keeping the aspect ratio.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while the pipeline does not hold. Three
// stages form the areas and the two 4*DIM_BITS bit products, then two dividers
// give one quotient bit per stage (2*DIM_BITS stages) and two square root
// units one root bit per stage (DIM_BITS stages), followed by the output
// register. The whole pipeline holds while a result waits at the output.
module area_fit_even_scaler
	import afes_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PORT_W-1:0] src_width,
	input  logic [PORT_W-1:0] src_height,
	input  logic [PORT_W-1:0] dst_width,
	input  logic [PORT_W-1:0] dst_height,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PORT_W-1:0] out_width,
	output logic [PORT_W-1:0] out_height,
	output logic [1:0]        outcome
);

	localparam int D   = DIM_BITS;
	localparam int A   = 2 * DIM_BITS;
	localparam int LAT = 3 * DIM_BITS;

	logic en;

	logic         vld_s1, vld_s2, vld_s3;
	logic [D-1:0] sw_s1, sh_s1, dw_s1, dh_s1;
	logic         zero_s2;
	logic [D-1:0] sw_s2, sh_s2;
	logic [A-1:0] src_area_s2, dst_area_s2, sw2_s2, sh2_s2;
	logic [A-1:0] src_area_s3;
	logic [2*A-1:0] numw_s3, numh_s3;
	outcome_t     mode_s3;
	logic [D-1:0] sw_s3, sh_s3;

	logic         vld_d  [0:LAT];
	outcome_t     mode_d [0:LAT];
	logic [D-1:0] sw_d   [0:LAT];
	logic [D-1:0] sh_d   [0:LAT];

	logic [A-1:0] quow, quoh;
	logic [D-1:0] rootw, rooth;

	logic              out_valid_q;
	logic [PORT_W-1:0] out_width_q, out_height_q;
	outcome_t          outcome_q;
	logic [D-1:0]      res_w, res_h;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s1 <= src_width[D-1:0];
			sh_s1 <= src_height[D-1:0];
			dw_s1 <= dst_width[D-1:0];
			dh_s1 <= dst_height[D-1:0];

			zero_s2     <= (sw_s1 == '0) || (sh_s1 == '0) || (dw_s1 == '0) || (dh_s1 == '0);
			sw_s2       <= sw_s1;
			sh_s2       <= sh_s1;
			src_area_s2 <= sw_s1 * sh_s1;
			dst_area_s2 <= dw_s1 * dh_s1;
			sw2_s2      <= sw_s1 * sw_s1;
			sh2_s2      <= sh_s1 * sh_s1;

			numw_s3     <= sw2_s2 * dst_area_s2;
			numh_s3     <= sh2_s2 * dst_area_s2;
			src_area_s3 <= src_area_s2;
			sw_s3       <= sw_s2;
			sh_s3       <= sh_s2;
			if (zero_s2) begin
				mode_s3 <= OUTCOME_ZERO;
			end else if (src_area_s2 <= dst_area_s2) begin
				mode_s3 <= OUTCOME_PASS;
			end else begin
				mode_s3 <= OUTCOME_SCALED;
			end
		end
	end

	// In the scaled case dst_area < src_area, so each quotient stays below
	// side squared and fits the divider's quotient width.
	afes_div #(.W(A)) u_div_w (.clk(clk), .en(en), .num(numw_s3), .den(src_area_s3), .quo(quow));
	afes_div #(.W(A)) u_div_h (.clk(clk), .en(en), .num(numh_s3), .den(src_area_s3), .quo(quoh));

	afes_sqrt #(.R(D)) u_sqrt_w (.clk(clk), .en(en), .val(quow), .root(rootw));
	afes_sqrt #(.R(D)) u_sqrt_h (.clk(clk), .en(en), .val(quoh), .root(rooth));

	// Side band travels alongside the divider and square root stages.
	assign vld_d[0]  = vld_s3;
	assign mode_d[0] = mode_s3;
	assign sw_d[0]   = sw_s3;
	assign sh_d[0]   = sh_s3;

	for (genvar i = 0; i < LAT; i++) begin : g_delay
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[i+1] <= 1'b0;
			end else if (en) begin
				vld_d[i+1] <= vld_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mode_d[i+1] <= mode_d[i];
				sw_d[i+1]   <= sw_d[i];
				sh_d[i+1]   <= sh_d[i];
			end
		end
	end

	always_comb begin
		case (mode_d[LAT])
			OUTCOME_PASS: begin
				res_w = sw_d[LAT];
				res_h = sh_d[LAT];
			end
			OUTCOME_SCALED: begin
				res_w = rootw & EVEN_MASK[D-1:0];
				res_h = rooth & EVEN_MASK[D-1:0];
			end
			default: begin
				res_w = '0;
				res_h = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_d[LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_width_q  <= PORT_W'(res_w);
			out_height_q <= PORT_W'(res_h);
			outcome_q    <= mode_d[LAT];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_width  = out_width_q;
	assign out_height = out_height_q;
	assign outcome    = outcome_q;

endmodule

// ===== src/afes_checker.sv =====
// ----------------------------------------------------------------------------
// afes_checker
// Port level checks for the area fit scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "area_fit_even_scaler_macros.svh"

module afes_checker
	import afes_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [PORT_W-1:0] src_width,
	input logic [PORT_W-1:0] src_height,
	input logic [PORT_W-1:0] dst_width,
	input logic [PORT_W-1:0] dst_height,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PORT_W-1:0] out_width,
	input logic [PORT_W-1:0] out_height,
	input logic [1:0]        outcome
);

	// A waiting result item holds its value until taken.
	`AFES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_width) && $stable(out_height) && $stable(outcome))

	// A scaled item always carries even sides.
	`AFES_ASSERT_NOW(a_scaled_even, out_valid && outcome == OUTCOME_SCALED, !out_width[0] && !out_height[0])

	// A zero item always reports an empty size.
	`AFES_ASSERT_NOW(a_zero_empty, out_valid && outcome == OUTCOME_ZERO, out_width == '0 && out_height == '0)

	// The input side only stalls while a result item waits.
	`AFES_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready)

endmodule

bind area_fit_even_scaler afes_checker u_afes_checker (.*);
